>>> sv/space_vector_pwm_duty_assert.svh
// Assertion macros shared by the duty calculator.
`ifndef SPACE_VECTOR_PWM_DUTY_ASSERT_SVH
`define SPACE_VECTOR_PWM_DUTY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SVPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svpd assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SVPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svpd assertion failed");

`endif

>>> sv/svpd_pkg.sv
package svpd_pkg;

    localparam int VOLT_BITS_DEF = 16;

    // Q.16 time constants
    localparam int ONE_Q16   = 65536;
    localparam int SQRT3_Q16 = 113512;
    localparam int TIME_W    = 17;

    // configuration port
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_IDX_BIT = 2;
    localparam logic CFG_DC_BUS     = 1'b0;
    localparam logic CFG_PWM_PERIOD = 1'b1;
    localparam logic [15:0] DC_BUS_RST = 16'd6144;
    localparam logic [15:0] PERIOD_RST = 16'd3600;

    // sector codes, named after the (T1, T2) pair they select
    localparam logic [2:0] SEC_NONE = 3'd0;
    localparam logic [2:0] SEC_ZY   = 3'd1;
    localparam logic [2:0] SEC_YNX  = 3'd2;
    localparam logic [2:0] SEC_NZX  = 3'd3;
    localparam logic [2:0] SEC_NXZ  = 3'd4;
    localparam logic [2:0] SEC_XNY  = 3'd5;
    localparam logic [2:0] SEC_NYNZ = 3'd6;
    localparam logic [2:0] SEC_ZERO = 3'd7;

    typedef struct packed {
        logic en;
        logic valid;
    } div_ctl_t;

endpackage

>>> sv/svpd_intf.sv
interface svpd_cmd_if #(
    parameter int VOLT_BITS = svpd_pkg::VOLT_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [VOLT_BITS-1:0] ualpha;
    logic signed [VOLT_BITS-1:0] ubeta;

    modport source (output valid, output ualpha, output ubeta, input ready);
    modport sink (input valid, input ualpha, input ubeta, output ready);
endinterface

interface svpd_duty_if;
    logic        valid;
    logic        ready;
    logic [15:0] phase_a_compare;
    logic [15:0] phase_b_compare;
    logic [15:0] phase_c_compare;
    logic [2:0]  sector_code;

    modport source (output valid, output phase_a_compare, output phase_b_compare,
                    output phase_c_compare, output sector_code, input ready);
    modport sink (input valid, input phase_a_compare, input phase_b_compare,
                  input phase_c_compare, input sector_code, output ready);
endinterface

>>> sv/space_vector_pwm_duty.sv
// Channel  Dir  Transfer when          Payload
// cmd      in   valid && ready         ualpha, ubeta (signed Q7.8)
// duty     out  valid && ready         phase_a/b/c_compare, sector_code
// APB      in   psel&&penable&&pwrite  dc_bus_voltage @0, pwm_period @4
//
// One command enters per cycle while the duty output is not stalled; the
// two bit-per-stage dividers have VOLT_BITS+18 and VOLT_BITS+34 stages.
// Reset clears all stage valid bits and loads the register reset values.
// A result held at duty stalls the whole pipeline; nothing is lost or repeated.
module space_vector_pwm_duty #(
    parameter int VOLT_BITS = svpd_pkg::VOLT_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    svpd_cmd_if.sink                           cmd,
    svpd_duty_if.source                        duty,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [svpd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    `include "space_vector_pwm_duty_assert.svh"

    localparam int PW = VOLT_BITS + 20;   // product width
    localparam int N1 = VOLT_BITS + 18;   // first quotient magnitude
    localparam int D1 = 17;
    localparam int TW = N1 + 1;           // signed time width
    localparam int N2 = VOLT_BITS + 34;
    localparam int D2 = VOLT_BITS + 19;
    localparam int TMW = svpd_pkg::TIME_W;

    // ---------------- configuration ----------------
    logic [15:0] dc_bus_reg;
    logic [15:0] period_reg;
    logic [15:0] udc_eff;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_bus_reg <= svpd_pkg::DC_BUS_RST;
            period_reg <= svpd_pkg::PERIOD_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[svpd_pkg::CFG_IDX_BIT] == svpd_pkg::CFG_DC_BUS)
                dc_bus_reg <= pwdata[15:0];
            else
                period_reg <= pwdata[15:0];
        end
    end

    // return the addressed register
    always_comb
    begin
        if (paddr[svpd_pkg::CFG_IDX_BIT] == svpd_pkg::CFG_PWM_PERIOD)
            prdata = {16'd0, period_reg};
        else
            prdata = {16'd0, dc_bus_reg};
    end

    // a zero bus voltage acts as one
    assign udc_eff = (dc_bus_reg == 16'd0) ? 16'd1 : dc_bus_reg;

    // ---------------- flow control ----------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic v3_next, v4_next;
    logic stall, en;

    assign stall     = v7_reg && !duty.ready;
    assign en        = !stall;
    assign cmd.ready = en;

    // ---------------- stage 0: capture ----------------
    logic signed [VOLT_BITS-1:0] ua0_reg, ub0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua0_reg <= cmd.ualpha;
            ub0_reg <= cmd.ubeta;
        end
    end

    // ---------------- stage 1: products ----------------
    logic signed [PW-1:0] sa1_reg, sb1_reg, u31_reg, ubs1_reg;
    logic signed [PW-1:0] ua_ext, ub_ext;

    assign ua_ext = PW'(ua0_reg);
    assign ub_ext = PW'(ub0_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa1_reg  <= ua_ext * PW'(svpd_pkg::SQRT3_Q16);
            sb1_reg  <= ub_ext * PW'(svpd_pkg::SQRT3_Q16);
            u31_reg  <= (ua_ext <<< 17) + (ua_ext <<< 16);
            ubs1_reg <= ub_ext <<< 16;
        end
    end

    // ---------------- stage 2: sector and numerators ----------------
    logic [2:0]             sec2_reg, sec2_next;
    logic [2:0][N1:0]       num2_reg, num2_next;
    logic signed [PW-1:0]   t_pos, t_neg, ny, nz, nx;

    always_comb
    begin
        t_pos = sa1_reg - ubs1_reg;
        t_neg = -sa1_reg - ubs1_reg;
        sec2_next = {!t_neg[PW-1], !t_pos[PW-1], !ubs1_reg[PW-1]};
        nx = sb1_reg <<< 1;
        ny = u31_reg + sb1_reg;
        nz = sb1_reg - u31_reg;
        num2_next[0] = nx[N1:0];
        num2_next[1] = ny[N1:0];
        num2_next[2] = nz[N1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec2_reg <= sec2_next;
            num2_reg <= num2_next;
        end
    end

    // ---------------- divide X, Y, Z by twice the bus voltage ----------------
    svpd_pkg::div_ctl_t div1_ctl, div2_ctl;
    logic [2:0][N1:0]   q1;
    logic [2:0]         sec_d1;

    assign div1_ctl.en    = en;
    assign div1_ctl.valid = v2_reg;

    svpd_div #(.LANES(3), .NW(N1), .DW(D1), .SW(3)) u_div_xyz (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div1_ctl),
        .num       (num2_reg),
        .den       ({udc_eff, 1'b0}),
        .side_in   (sec2_reg),
        .valid_out (v3_next),
        .quo       (q1),
        .side_out  (sec_d1)
    );

    // ---------------- stage 3: pick T1, T2 and set up rescale ----------------
    logic signed [TW-1:0] x3, y3, z3, t1s, t2s;
    logic signed [TW:0]   sum3;
    logic                 over3;
    logic [1:0][N2:0]     num3_reg, num3_next;
    logic [D2-1:0]        den3_reg, den3_next;
    logic [2:0]           sec3_reg;

    always_comb
    begin
        x3 = $signed(q1[0]);
        y3 = $signed(q1[1]);
        z3 = $signed(q1[2]);
        case (sec_d1)
            svpd_pkg::SEC_ZY:   begin t1s = z3;  t2s = y3;  end
            svpd_pkg::SEC_YNX:  begin t1s = y3;  t2s = -x3; end
            svpd_pkg::SEC_NZX:  begin t1s = -z3; t2s = x3;  end
            svpd_pkg::SEC_NXZ:  begin t1s = -x3; t2s = z3;  end
            svpd_pkg::SEC_XNY:  begin t1s = x3;  t2s = -y3; end
            svpd_pkg::SEC_NYNZ: begin t1s = -y3; t2s = -z3; end
            default:            begin t1s = '0;  t2s = '0;  end
        endcase
        sum3  = (TW+1)'(t1s) + (TW+1)'(t2s);
        over3 = sum3 > (TW+1)'(svpd_pkg::ONE_Q16);
        // divide by one when no rescale is needed
        if (over3)
        begin
            num3_next[0] = (N2+1)'(t1s) <<< 16;
            num3_next[1] = (N2+1)'(t2s) <<< 16;
            den3_next    = sum3[D2-1:0];
        end
        else
        begin
            num3_next[0] = (N2+1)'(t1s);
            num3_next[1] = (N2+1)'(t2s);
            den3_next    = D2'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num3_reg <= num3_next;
            den3_reg <= den3_next;
            sec3_reg <= sec_d1;
        end
    end

    // ---------------- rescale divider ----------------
    logic [1:0][N2:0] q2;
    logic [2:0]       sec_d2;

    assign div2_ctl.en    = en;
    assign div2_ctl.valid = v3_reg;

    svpd_div #(.LANES(2), .NW(N2), .DW(D2), .SW(3)) u_div_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div2_ctl),
        .num       (num3_reg),
        .den       (den3_reg),
        .side_in   (sec3_reg),
        .valid_out (v4_next),
        .quo       (q2),
        .side_out  (sec_d2)
    );

    // ---------------- stage 4: clamp times ----------------
    function automatic logic [TMW-1:0] clamp_t(input logic signed [N2+2:0] v);
        if (v < 0)
            clamp_t = '0;
        else if (v > (N2+3)'(svpd_pkg::ONE_Q16))
            clamp_t = TMW'(svpd_pkg::ONE_Q16);
        else
            clamp_t = v[TMW-1:0];
    endfunction

    logic signed [N2+2:0] t1w, t2w, t0w;
    logic [TMW-1:0]       t0c4_reg, t1c4_reg, t2c4_reg;
    logic [2:0]           sec4_reg;

    always_comb
    begin
        t1w = (N2+3)'($signed(q2[0]));
        t2w = (N2+3)'($signed(q2[1]));
        t0w = (N2+3)'(svpd_pkg::ONE_Q16) - t1w - t2w;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0c4_reg <= clamp_t(t0w);
            t1c4_reg <= clamp_t(t1w);
            t2c4_reg <= clamp_t(t2w);
            sec4_reg <= sec_d2;
        end
    end

    // ---------------- stage 5: compare points and phase map ----------------
    logic [TMW-1:0] ta, tb, tc, ca5, cb5, cc5;
    logic [TMW-1:0] ca5_reg, cb5_reg, cc5_reg;
    logic [2:0]     sec5_reg;

    always_comb
    begin
        ta = t0c4_reg >> 2;
        tb = ta + (t1c4_reg >> 1);
        tc = tb + (t2c4_reg >> 1);
        case (sec4_reg)
            svpd_pkg::SEC_ZY:   begin ca5 = tb; cb5 = ta; cc5 = tc; end
            svpd_pkg::SEC_YNX:  begin ca5 = ta; cb5 = tc; cc5 = tb; end
            svpd_pkg::SEC_NZX:  begin ca5 = ta; cb5 = tb; cc5 = tc; end
            svpd_pkg::SEC_NXZ:  begin ca5 = tc; cb5 = tb; cc5 = ta; end
            svpd_pkg::SEC_XNY:  begin ca5 = tc; cb5 = ta; cc5 = tb; end
            svpd_pkg::SEC_NYNZ: begin ca5 = tb; cb5 = tc; cc5 = ta; end
            default:            begin ca5 = '0; cb5 = '0; cc5 = '0; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca5_reg  <= ca5;
            cb5_reg  <= cb5;
            cc5_reg  <= cc5;
            sec5_reg <= sec4_reg;
        end
    end

    // ---------------- stage 6: scale by PWM period ----------------
    logic [TMW+15:0] pa6_reg, pb6_reg, pc6_reg;
    logic [2:0]      sec6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa6_reg  <= (TMW+16)'(ca5_reg) * (TMW+16)'(period_reg);
            pb6_reg  <= (TMW+16)'(cb5_reg) * (TMW+16)'(period_reg);
            pc6_reg  <= (TMW+16)'(cc5_reg) * (TMW+16)'(period_reg);
            sec6_reg <= sec5_reg;
        end
    end

    // ---------------- stage 7: saturate into output register ----------------
    function automatic logic [15:0] sat16(input logic [TMW+15:0] p);
        if (p[TMW+15:32] != '0)
            sat16 = 16'hFFFF;
        else
            sat16 = p[31:16];
    endfunction

    logic [15:0] ca7_reg, cb7_reg, cc7_reg;
    logic [2:0]  sec7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca7_reg  <= sat16(pa6_reg);
            cb7_reg  <= sat16(pb6_reg);
            cc7_reg  <= sat16(pc6_reg);
            sec7_reg <= sec6_reg;
        end
    end

    assign duty.valid           = v7_reg;
    assign duty.phase_a_compare = ca7_reg;
    assign duty.phase_b_compare = cb7_reg;
    assign duty.phase_c_compare = cc7_reg;
    assign duty.sector_code     = sec7_reg;

    // advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= cmd.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // ---------------- assertions ----------------
    `SVPD_ASSERT_IMPL(a_zero_vector, duty.valid && (duty.sector_code == svpd_pkg::SEC_ZERO || duty.sector_code == svpd_pkg::SEC_NONE), duty.phase_a_compare == 16'd0 && duty.phase_b_compare == 16'd0 && duty.phase_c_compare == 16'd0)
    `SVPD_ASSERT_NEXT(a_stall_freeze, stall, $stable(v3_reg) && $stable(sec3_reg) && $stable(v6_reg))
    `SVPD_ASSERT_IMPL(a_clamped_time, v4_reg, t0c4_reg <= TMW'(svpd_pkg::ONE_Q16) && t1c4_reg <= TMW'(svpd_pkg::ONE_Q16))

endmodule

>>> sv/svpd_div.sv
module svpd_div #(
    parameter int LANES = 3,
    parameter int NW    = 34,
    parameter int DW    = 17,
    parameter int SW    = 3
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  svpd_pkg::div_ctl_t        ctl,
    input  logic [LANES-1:0][NW:0]    num,
    input  logic [DW-1:0]             den,
    input  logic [SW-1:0]             side_in,
    output logic                      valid_out,
    output logic [LANES-1:0][NW:0]    quo,
    output logic [SW-1:0]             side_out
);

    logic                         vld_reg  [NW];
    logic [LANES-1:0][DW-1:0]     rem_reg  [NW];
    logic [LANES-1:0][NW-1:0]     quo_reg  [NW];
    logic [LANES-1:0]             neg_reg  [NW];
    logic [DW-1:0]                den_reg  [NW];
    logic [SW-1:0]                side_reg [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_stage
            logic                     vld_in;
            logic [LANES-1:0][DW-1:0] rem_in;
            logic [LANES-1:0][NW-1:0] quo_in;
            logic [LANES-1:0]         neg_in;
            logic [DW-1:0]            den_in;
            logic [SW-1:0]            side_in_s;
            logic [LANES-1:0][DW-1:0] rem_next;
            logic [LANES-1:0][NW-1:0] quo_next;

            if (k == 0)
            begin : g_first
                // take magnitudes, keep signs
                always_comb
                begin
                    logic [NW:0] mag;
                    mag       = '0;
                    vld_in    = ctl.valid;
                    den_in    = den;
                    side_in_s = side_in;
                    for (int l = 0; l < LANES; l++)
                    begin
                        mag       = num[l][NW] ? (NW+1)'(-num[l]) : num[l];
                        neg_in[l] = num[l][NW];
                        quo_in[l] = mag[NW-1:0];
                        rem_in[l] = '0;
                    end
                end
            end
            else
            begin : g_rest
                assign vld_in    = vld_reg[k-1];
                assign rem_in    = rem_reg[k-1];
                assign quo_in    = quo_reg[k-1];
                assign neg_in    = neg_reg[k-1];
                assign den_in    = den_reg[k-1];
                assign side_in_s = side_reg[k-1];
            end

            // one restoring step per lane
            always_comb
            begin
                logic [DW:0]   shifted;
                logic [DW+1:0] diff;
                shifted = '0;
                diff    = '0;
                for (int l = 0; l < LANES; l++)
                begin
                    shifted = {rem_in[l], quo_in[l][NW-1]};
                    diff    = {1'b0, shifted} - {2'b00, den_in};
                    if (!diff[DW+1])
                    begin
                        rem_next[l] = diff[DW-1:0];
                        quo_next[l] = {quo_in[l][NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = shifted[DW-1:0];
                        quo_next[l] = {quo_in[l][NW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (ctl.en)
                    vld_reg[k] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    rem_reg[k]  <= rem_next;
                    quo_reg[k]  <= quo_next;
                    neg_reg[k]  <= neg_in;
                    den_reg[k]  <= den_in;
                    side_reg[k] <= side_in_s;
                end
            end
        end
    endgenerate

    // restore signs
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (neg_reg[NW-1][l])
                quo[l] = (NW+1)'(-{1'b0, quo_reg[NW-1][l]});
            else
                quo[l] = {1'b0, quo_reg[NW-1][l]};
        end
    end

    assign valid_out = vld_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

>>> verif/tb.sv
module tb;

    localparam int LATENCY   = 2 * svpd_pkg::VOLT_BITS_DEF + 60;
    localparam int N_RANDOM  = 960;
    localparam longint CYCLE_LIMIT = 400000;

    // Predict compare values from the current register settings
    class duty_scoreboard;
        logic [15:0] exp_a[$];
        logic [15:0] exp_b[$];
        logic [15:0] exp_c[$];
        logic [2:0]  exp_sec[$];
        logic [15:0] bus_v;
        logic [15:0] period;
        int          errors;

        function new();
            bus_v  = svpd_pkg::DC_BUS_RST;
            period = svpd_pkg::PERIOD_RST;
            errors = 0;
        endfunction

        function longint clamp_q16(longint t);
            if (t < 0)
                return 0;
            if (t > svpd_pkg::ONE_Q16)
                return svpd_pkg::ONE_Q16;
            return t;
        endfunction

        function logic [15:0] counts(longint t);
            longint c;
            c = (t * longint'(period)) >>> 16;
            return (c > 65535) ? 16'hFFFF : c[15:0];
        endfunction

        function void note_command(logic signed [15:0] ua_in, logic signed [15:0] ub_in);
            longint ua, ub, udc, sa, sb, x, y, z, t1, t2, t0, ta, tb, tc, s, ca, cb, cc;
            logic [2:0] sec;
            ua = ua_in;
            ub = ub_in;
            udc = (bus_v == 0) ? 1 : longint'(bus_v);
            sa = svpd_pkg::SQRT3_Q16 * ua;
            sb = svpd_pkg::SQRT3_Q16 * ub;
            sec = 3'b000;
            if (ub >= 0) sec[0] = 1'b1;
            if (sa - ub * svpd_pkg::ONE_Q16 >= 0) sec[1] = 1'b1;
            if (-sa - ub * svpd_pkg::ONE_Q16 >= 0) sec[2] = 1'b1;
            x = sb / udc;
            y = (3 * svpd_pkg::ONE_Q16 * ua + sb) / (2 * udc);
            z = (-3 * svpd_pkg::ONE_Q16 * ua + sb) / (2 * udc);
            case (sec)
                svpd_pkg::SEC_ZY:   begin t1 = z;  t2 = y;  end
                svpd_pkg::SEC_YNX:  begin t1 = y;  t2 = -x; end
                svpd_pkg::SEC_NZX:  begin t1 = -z; t2 = x;  end
                svpd_pkg::SEC_NXZ:  begin t1 = -x; t2 = z;  end
                svpd_pkg::SEC_XNY:  begin t1 = x;  t2 = -y; end
                svpd_pkg::SEC_NYNZ: begin t1 = -y; t2 = -z; end
                default:            begin t1 = 0;  t2 = 0;  end
            endcase
            // rescale on overmodulation, both by the original sum
            if (t1 + t2 > svpd_pkg::ONE_Q16)
            begin
                s  = t1 + t2;
                t1 = (t1 * svpd_pkg::ONE_Q16) / s;
                t2 = (t2 * svpd_pkg::ONE_Q16) / s;
            end
            t0 = clamp_q16(svpd_pkg::ONE_Q16 - t1 - t2);
            t1 = clamp_q16(t1);
            t2 = clamp_q16(t2);
            ta = t0 >>> 2;
            tb = ta + (t1 >>> 1);
            tc = tb + (t2 >>> 1);
            ca = 0; cb = 0; cc = 0;
            case (sec)
                svpd_pkg::SEC_ZY:   begin ca = tb; cb = ta; cc = tc; end
                svpd_pkg::SEC_YNX:  begin ca = ta; cb = tc; cc = tb; end
                svpd_pkg::SEC_NZX:  begin ca = ta; cb = tb; cc = tc; end
                svpd_pkg::SEC_NXZ:  begin ca = tc; cb = tb; cc = ta; end
                svpd_pkg::SEC_XNY:  begin ca = tc; cb = ta; cc = tb; end
                svpd_pkg::SEC_NYNZ: begin ca = tb; cb = tc; cc = ta; end
                default:  ;
            endcase
            exp_a.push_back(counts(ca));
            exp_b.push_back(counts(cb));
            exp_c.push_back(counts(cc));
            exp_sec.push_back(sec);
        endfunction

        function void check_duty(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                 logic [2:0] sec);
            logic [15:0] ea, eb, ec;
            logic [2:0]  es;
            if (exp_sec.size() == 0)
            begin
                $display("%0t: unexpected duty transfer a=%0d b=%0d c=%0d sector=%0d",
                         $time, a, b, c, sec);
                errors++;
                return;
            end
            ea = exp_a.pop_front();
            eb = exp_b.pop_front();
            ec = exp_c.pop_front();
            es = exp_sec.pop_front();
            if (a !== ea)
            begin
                $display("%0t: phase_a_compare expected %0d actual %0d", $time, ea, a);
                errors++;
            end
            if (b !== eb)
            begin
                $display("%0t: phase_b_compare expected %0d actual %0d", $time, eb, b);
                errors++;
            end
            if (c !== ec)
            begin
                $display("%0t: phase_c_compare expected %0d actual %0d", $time, ec, c);
                errors++;
            end
            if (sec !== es)
            begin
                $display("%0t: sector_code expected %0d actual %0d", $time, es, sec);
                errors++;
            end
        endfunction

        function int pending();
            return exp_sec.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [svpd_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    longint      cycles;
    int          stall_mode;

    svpd_cmd_if  cmd_ch ();
    svpd_duty_if duty_ch ();

    duty_scoreboard sb;

    space_vector_pwm_duty uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch.sink),
        .duty    (duty_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check every duty transfer and count cycles
    always @(posedge clk)
    begin
        if (!rst_n)
            cycles <= 0;
        else
            cycles <= cycles + 1;
        if (rst_n && duty_ch.valid && duty_ch.ready)
            sb.check_duty(duty_ch.phase_a_compare, duty_ch.phase_b_compare,
                          duty_ch.phase_c_compare, duty_ch.sector_code);
    end

    // Stall the receiver on a pattern that changes mode now and then
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            duty_ch.ready <= 1'b0;
            stall_mode    <= 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: duty_ch.ready <= 1'b1;
                1: duty_ch.ready <= ($urandom_range(0, 3) != 0);
                2: duty_ch.ready <= ($urandom_range(0, 1) != 0);
                default: duty_ch.ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Write one register through the APB port
    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= svpd_pkg::CFG_ADDR_W'(idx) << svpd_pkg::CFG_IDX_BIT;
        pwdata  <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == svpd_pkg::CFG_DC_BUS)
            sb.bus_v = value;
        else
            sb.period = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Send one command and hold it until the transfer
    task automatic send_cmd(input logic [15:0] ua, input logic [15:0] ub);
        cmd_ch.valid  <= 1'b1;
        cmd_ch.ualpha <= ua;
        cmd_ch.ubeta  <= ub;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sb.note_command(ua, ub);
        @(negedge clk);
    endtask

    // Drop valid for a random gap
    task automatic idle_cmd(input int n);
        cmd_ch.valid  <= 1'b0;
        cmd_ch.ualpha <= $urandom();
        cmd_ch.ubeta  <= $urandom();
        repeat (n) @(negedge clk);
    endtask

    // Wait for every expected result, then let the pipeline drain
    task automatic drain();
        idle_cmd(0);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    // Random command, mostly within the linear range with some extremes
    task automatic random_cmd(output logic [15:0] ua, output logic [15:0] ub);
        case ($urandom_range(0, 5))
            0: begin ua = $urandom(); ub = $urandom(); end
            1: begin ua = $urandom_range(0, 15) - 8; ub = $urandom_range(0, 15) - 8; end
            2: begin ua = $urandom_range(0, 511) - 256; ub = 16'd0; end
            default:
            begin
                ua = $urandom_range(0, 8191) - 4096;
                ub = $urandom_range(0, 8191) - 4096;
            end
        endcase
    endtask

    // Directed commands followed by random bursts with idle gaps
    task automatic run_phase(input int n_random);
        logic [15:0] ua, ub;
        int burst;
        send_cmd(16'd0, 16'd0);
        send_cmd(16'h7FFF, 16'h7FFF);
        send_cmd(16'h8000, 16'h8000);
        send_cmd(16'h7FFF, 16'h8000);
        send_cmd(16'h8000, 16'h7FFF);
        send_cmd(16'h0100, 16'h0000);
        send_cmd(16'hFF00, 16'h0000);
        send_cmd(16'h0000, 16'h0100);
        send_cmd(16'h0000, 16'hFF00);
        send_cmd(16'h0080, 16'h00DE);
        send_cmd(16'hFF80, 16'hFF22);
        send_cmd(16'h0000, 16'hFFFF);
        send_cmd(16'hFFFF, 16'h0000);
        send_cmd(16'h5555, 16'hAAAA);
        while (n_random > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && n_random > 0)
            begin
                random_cmd(ua, ub);
                send_cmd(ua, ub);
                burst--;
                n_random--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cmd($urandom_range(1, 30));
        end
        drain();
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.ualpha = '0;
        cmd_ch.ubeta  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_phase(N_RANDOM / 4);
        write_reg(svpd_pkg::CFG_DC_BUS, 16'd1);
        write_reg(svpd_pkg::CFG_PWM_PERIOD, 16'hFFFF);
        run_phase(N_RANDOM / 4);
        write_reg(svpd_pkg::CFG_DC_BUS, 16'hFFFF);
        write_reg(svpd_pkg::CFG_PWM_PERIOD, 16'd1);
        run_phase(N_RANDOM / 4);
        write_reg(svpd_pkg::CFG_DC_BUS, 16'd0);
        write_reg(svpd_pkg::CFG_PWM_PERIOD, 16'd0);
        run_phase(20);
        write_reg(svpd_pkg::CFG_DC_BUS, 16'd3000);
        write_reg(svpd_pkg::CFG_PWM_PERIOD, 16'd50000);
        run_phase(N_RANDOM / 4);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
